/* rtl/fpd_pkg.sv */
// Shared types and constants of the fall and panic detector.
// No dependencies; every other file in rtl/ refers to this package.
`timescale 1ns / 1ps

package fpd_pkg;

	localparam int TIME_W  = 32;
	localparam int AXIS_W  = 16;
	localparam int TICK_W  = 16;
	localparam int SQ_W    = 32;
	localparam int AXSQ_W  = 31;  // one axis squared, largest is 2^30
	localparam int RUN_W   = 16;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 32;
	localparam int IN_DATA_W = 88; // 81 payload bits padded to whole bytes

	localparam int QUEUE_DEPTH = 4;

	localparam logic [TICK_W-1:0] RST_DEBOUNCE  = 16'd50;
	localparam logic [SQ_W-1:0]   RST_FF_LEVEL  = 32'd67108864;
	localparam logic [TICK_W-1:0] RST_FF_NEEDED = 16'd3;
	localparam logic [SQ_W-1:0]   RST_IMP_LEVEL = 32'd1677721600;
	localparam logic [TICK_W-1:0] RST_WINDOW    = 16'd1000;
	localparam logic [TICK_W-1:0] RST_COOLDOWN  = 16'd8000;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam logic CAUSE_BUTTON = 1'b0;
	localparam logic CAUSE_FALL   = 1'b1;

	typedef enum logic [CIDX_W-1:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_FF_LEVEL  = 3'd1,
		REG_FF_NEEDED = 3'd2,
		REG_IMP_LEVEL = 3'd3,
		REG_WINDOW    = 3'd4,
		REG_COOLDOWN  = 3'd5
	} reg_idx_t;

	// code 1 is never entered
	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_IMPACT   = 2'd2,
		MODE_COOLDOWN = 2'd3
	} fall_mode_t;

	typedef struct packed {
		logic [TICK_W-1:0] debounce_ticks;
		logic [SQ_W-1:0]   freefall_level_sq;
		logic [TICK_W-1:0] freefall_needed;
		logic [SQ_W-1:0]   impact_level_sq;
		logic [TICK_W-1:0] impact_window_ticks;
		logic [TICK_W-1:0] cooldown_ticks;
	} cfg_t;

	// alerts raised by one sample
	typedef struct packed {
		logic            btn;
		logic            fall;
		logic [SQ_W-1:0] sq;
	} alert_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* rtl/fpd_front.sv */
// Front end: sample intake, axis squaring, button debounce and fall tracking.
// Uses fpd_pkg; pushes one alert record per alerting sample toward the queue.
`timescale 1ns / 1ps

module fpd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fpd_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fpd_pkg::TIME_W-1:0]        time_now,
	input  logic                              button_level,
	input  logic                              accel_ok,
	input  logic signed [fpd_pkg::AXIS_W-1:0] accel_x,
	input  logic signed [fpd_pkg::AXIS_W-1:0] accel_y,
	input  logic signed [fpd_pkg::AXIS_W-1:0] accel_z,
	input  fpd_pkg::q_stat_t                  q_stat,
	output logic                              push,
	output fpd_pkg::alert_rec_t               push_rec
);

	localparam int MAG_W = fpd_pkg::AXIS_W + 1;
	localparam int PRD_W = 2 * MAG_W;

	logic accept, commit;

	logic [MAG_W-1:0] mag_x, mag_y, mag_z;
	logic [PRD_W-1:0] prd_x, prd_y, prd_z;

	logic                         s1_valid_q;
	logic [fpd_pkg::TIME_W-1:0]   time_s1;
	logic                         raw_s1;
	logic                         ok_s1;
	logic [fpd_pkg::AXSQ_W-1:0]   sqx_s1, sqy_s1, sqz_s1;

	logic                         prev_raw_q, stable_q;
	logic [fpd_pkg::TIME_W-1:0]   change_q;
	fpd_pkg::fall_mode_t          mode_q;
	logic [fpd_pkg::RUN_W-1:0]    run_q;
	logic [fpd_pkg::TIME_W-1:0]   mark_q;

	logic                         stable_d;
	logic [fpd_pkg::TIME_W-1:0]   change_d, btn_elapsed, mark_elapsed;
	fpd_pkg::fall_mode_t          mode_d;
	logic [fpd_pkg::RUN_W-1:0]    run_d, run_inc;
	logic [fpd_pkg::TIME_W-1:0]   mark_d;
	logic [fpd_pkg::SQ_W-1:0]     sum;
	logic                         btn_alert, fall_alert;

	assign commit   = s1_valid_q && !q_stat.full;
	assign in_ready = !s1_valid_q || commit;
	assign accept   = in_valid && in_ready;

	// magnitude 0..32768, the most negative code included
	function automatic logic [MAG_W-1:0] abs_axis(input logic [fpd_pkg::AXIS_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {1'b0, v};
		abs_axis = v[fpd_pkg::AXIS_W-1] ? ((MAG_W'(1) << fpd_pkg::AXIS_W) - ext) : ext;
	endfunction

	assign mag_x = abs_axis($unsigned(accel_x));
	assign mag_y = abs_axis($unsigned(accel_y));
	assign mag_z = abs_axis($unsigned(accel_z));
	assign prd_x = {{MAG_W{1'b0}}, mag_x} * {{MAG_W{1'b0}}, mag_x};
	assign prd_y = {{MAG_W{1'b0}}, mag_y} * {{MAG_W{1'b0}}, mag_y};
	assign prd_z = {{MAG_W{1'b0}}, mag_z} * {{MAG_W{1'b0}}, mag_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !commit);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_s1 <= time_now;
			raw_s1  <= button_level;
			ok_s1   <= accel_ok;
			sqx_s1  <= prd_x[fpd_pkg::AXSQ_W-1:0];
			sqy_s1  <= prd_y[fpd_pkg::AXSQ_W-1:0];
			sqz_s1  <= prd_z[fpd_pkg::AXSQ_W-1:0];
		end
	end

	// button debounce
	always_comb begin
		change_d    = (raw_s1 != prev_raw_q) ? time_s1 : change_q;
		btn_elapsed = time_s1 - change_d;
		stable_d    = stable_q;
		btn_alert   = 1'b0;
		if (btn_elapsed > {16'd0, cfg.debounce_ticks} && raw_s1 != stable_q) begin
			stable_d  = raw_s1;
			btn_alert = !raw_s1;
		end
	end

	// fall tracking, frozen on samples without valid axes
	always_comb begin
		sum = {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
		mark_elapsed = time_s1 - mark_q;
		run_inc = (run_q == fpd_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
		mode_d = mode_q;
		run_d  = run_q;
		mark_d = mark_q;
		fall_alert = 1'b0;
		if (ok_s1) begin
			case (mode_q)
				fpd_pkg::MODE_IDLE: begin
					if (sum < cfg.freefall_level_sq) begin
						run_d = run_inc;
						if (run_inc >= cfg.freefall_needed) begin
							mark_d = time_s1;
							mode_d = fpd_pkg::MODE_IMPACT;
						end
					end else begin
						run_d = '0;
					end
				end
				fpd_pkg::MODE_IMPACT: begin
					if (sum > cfg.impact_level_sq) begin
						fall_alert = 1'b1;
						mark_d = time_s1;
						mode_d = fpd_pkg::MODE_COOLDOWN;
					end else if (mark_elapsed > {16'd0, cfg.impact_window_ticks}) begin
						run_d  = '0;
						mode_d = fpd_pkg::MODE_IDLE;
					end
				end
				fpd_pkg::MODE_COOLDOWN: begin
					if (mark_elapsed > {16'd0, cfg.cooldown_ticks}) begin
						run_d  = '0;
						mode_d = fpd_pkg::MODE_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= 1'b1;
			stable_q   <= 1'b1;
			change_q   <= '0;
			mode_q     <= fpd_pkg::MODE_IDLE;
			run_q      <= '0;
			mark_q     <= '0;
		end else if (commit) begin
			prev_raw_q <= raw_s1;
			stable_q   <= stable_d;
			change_q   <= change_d;
			mode_q     <= mode_d;
			run_q      <= run_d;
			mark_q     <= mark_d;
		end
	end

	assign push          = commit && (btn_alert || fall_alert);
	assign push_rec.btn  = btn_alert;
	assign push_rec.fall = fall_alert;
	assign push_rec.sq   = sum;

	a_fall_from_watch: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_rec.fall) |-> (mode_q == fpd_pkg::MODE_IMPACT && ok_s1))
		else $error("fall alert outside impact watch");

endmodule

/* rtl/fpd_queue.sv */
// Short alert queue between the front end and the output stage.
// Uses fpd_pkg for the record and status types.
`timescale 1ns / 1ps

module fpd_queue #(
	parameter int DEPTH = fpd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fpd_pkg::alert_rec_t push_rec,
	input  logic                pop,
	output fpd_pkg::alert_rec_t head_rec,
	output fpd_pkg::q_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	fpd_pkg::alert_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_FULL);
	assign stat.empty = (cnt_q == '0);
	assign head_rec   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full && !(pop && stat.empty)))
		else $error("queue overrun or underrun");

endmodule

/* rtl/fpd_back.sv */
// Output stage: expands queued alert records into result requests.
// Uses fpd_pkg; a record with both alerts gives the button request first.
`timescale 1ns / 1ps

module fpd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fpd_pkg::alert_rec_t          head_rec,
	input  fpd_pkg::q_stat_t             q_stat,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [fpd_pkg::SQ_W-1:0]     m_tdata,
	output logic                         m_tuser,
	output logic                         m_tlast
);

	logic load, take, split_first;
	logic phase_q, valid_q, cause_q, last_q;
	logic [fpd_pkg::SQ_W-1:0] sq_q;

	assign load        = !valid_q || m_tready;
	assign take        = load && !q_stat.empty;
	assign split_first = head_rec.btn && head_rec.fall && !phase_q;
	assign pop         = take && !split_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_stat.empty;
			if (take) begin
				phase_q <= split_first;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (split_first) begin
				cause_q <= fpd_pkg::CAUSE_BUTTON;
				sq_q    <= '0;
				last_q  <= 1'b0;
			end else begin
				cause_q <= head_rec.fall ? fpd_pkg::CAUSE_FALL : fpd_pkg::CAUSE_BUTTON;
				sq_q    <= head_rec.fall ? head_rec.sq : '0;
				last_q  <= 1'b1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = sq_q;
	assign m_tuser  = cause_q;
	assign m_tlast  = last_q;

	a_split_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (!q_stat.empty && head_rec.btn && head_rec.fall))
		else $error("second half of a record lost");

	a_first_is_button: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == fpd_pkg::CAUSE_BUTTON && m_tdata == '0))
		else $error("non-final request is not a button alert");

	a_button_no_sq: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !split_first && !head_rec.fall) |=> (sq_q == '0))
		else $error("button alert carries a magnitude");

endmodule

/* rtl/fall_and_panic_detector.sv */
// Top level of the fall and panic detector: register file and block wiring.
// Uses fpd_pkg, fpd_front, fpd_queue and fpd_back.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  tdata: time_now[31:0] button_level[32]
//                                          accel_x[48:33] accel_y[64:49] accel_z[80:65]
//                                    tuser: accel_ok
//   m_       out  m_tvalid/m_tready  tdata: impact_sq; tuser: alert_cause; tlast: last_alert
//   cfg_     in   cfg_valid/cfg_ready cfg_index (register number), cfg_data
//
// One sample per clock while the alert queue is not full. Axis squares are
// registered at intake; the state update and alert push act on that register,
// and a pushed record passes through the queue into the output register. A
// sample raising both alerts fills the output register twice, button first.
// Reset is asynchronous and loads the register defaults; no clearing pass.
// Intake stalls only while the alert queue is full, which happens when m_tready stays low.
`timescale 1ns / 1ps

module fall_and_panic_detector #(
	parameter int QUEUE_DEPTH = fpd_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fpd_pkg::IN_DATA_W-1:0]  s_tdata,  // time_now, button_level, accel_x/y/z
	input  logic                           s_tuser,  // accel_ok
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fpd_pkg::SQ_W-1:0]       m_tdata,  // impact_sq
	output logic                           m_tuser,  // alert_cause
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fpd_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [fpd_pkg::CDATA_W-1:0]    cfg_data
);

	fpd_pkg::cfg_t       cfg_q;
	fpd_pkg::q_stat_t    q_stat;
	fpd_pkg::alert_rec_t push_rec, head_rec;
	logic push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks      <= fpd_pkg::RST_DEBOUNCE;
			cfg_q.freefall_level_sq   <= fpd_pkg::RST_FF_LEVEL;
			cfg_q.freefall_needed     <= fpd_pkg::RST_FF_NEEDED;
			cfg_q.impact_level_sq     <= fpd_pkg::RST_IMP_LEVEL;
			cfg_q.impact_window_ticks <= fpd_pkg::RST_WINDOW;
			cfg_q.cooldown_ticks      <= fpd_pkg::RST_COOLDOWN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpd_pkg::REG_DEBOUNCE:  cfg_q.debounce_ticks      <= cfg_data[15:0];
				fpd_pkg::REG_FF_LEVEL:  cfg_q.freefall_level_sq   <= cfg_data;
				fpd_pkg::REG_FF_NEEDED: cfg_q.freefall_needed     <= cfg_data[15:0];
				fpd_pkg::REG_IMP_LEVEL: cfg_q.impact_level_sq     <= cfg_data;
				fpd_pkg::REG_WINDOW:    cfg_q.impact_window_ticks <= cfg_data[15:0];
				fpd_pkg::REG_COOLDOWN:  cfg_q.cooldown_ticks      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	fpd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.time_now     (s_tdata[31:0]),
		.button_level (s_tdata[32]),
		.accel_ok     (s_tuser),
		.accel_x      ($signed(s_tdata[48:33])),
		.accel_y      ($signed(s_tdata[64:49])),
		.accel_z      ($signed(s_tdata[80:65])),
		.q_stat       (q_stat),
		.push         (push),
		.push_rec     (push_rec)
	);

	fpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.stat     (q_stat)
	);

	fpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_rec (head_rec),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
